/* sv/rrts_pkg.sv */
// ============================================================================
// rrts_pkg
// Shared types and codes of the round robin thread slot scheduler.
// ============================================================================
package rrts_pkg;

   localparam int TIME_W    = 32;
   localparam int QUANTUM_W = 16;
   localparam int TID_W     = 16;
   localparam int CSLOT_W   = 5;
   localparam int LIVE_W    = 6;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd200;

   // Event codes carried in the mode field.
   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_EXIT   = 2'd1;
   localparam logic [1:0] MODE_YIELD  = 2'd2;

   // Result status codes.
   localparam logic [1:0] RSP_OK      = 2'd0;
   localparam logic [1:0] RSP_NO_SLOT = 2'd1;
   localparam logic [1:0] RSP_HALTED  = 2'd2;

   // Slot states as held in the slot memory.
   localparam logic [1:0] SLOT_DEAD    = 2'd0;
   localparam logic [1:0] SLOT_READY   = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_WR_OLD,
      S_WR_NEW,
      S_RESP
   } sched_state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TIME_W-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [TID_W-1:0]   thread_id;
      logic [CSLOT_W-1:0] current_slot;
      logic               switched;
      logic [LIVE_W-1:0]  live_count;
   } rsp_payload_type;

endpackage

/* sv/rrts_slot_mem.sv */
// ============================================================================
// rrts_slot_mem
// Slot table memory: status, thread id and start time of every slot, one
// write port and one registered read port. Entries never written since reset
// read as their reset value: slot zero running, all others dead, fields zero.
// ============================================================================
module rrts_slot_mem
   import rrts_pkg::*;
#(
   parameter int SLOT_COUNT = 32,
   parameter int ID_BITS    = 16,
   localparam int SLOT_W    = $clog2(SLOT_COUNT),
   localparam int ENTRY_W   = 2 + ID_BITS + TIME_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SLOT_W-1:0]  rd_addr,
   output logic [1:0]         rd_status,
   output logic [ID_BITS-1:0] rd_ident,
   output logic [TIME_W-1:0]  rd_start,
   input  logic               wr_en,
   input  logic [SLOT_W-1:0]  wr_addr,
   input  logic [1:0]         wr_status,
   input  logic [ID_BITS-1:0] wr_ident,
   input  logic [TIME_W-1:0]  wr_start
);

   logic [ENTRY_W-1:0]    slot_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] written_ff;
   logic [ENTRY_W-1:0]    rd_entry_ff;
   logic                  rd_hit_ff;
   logic                  rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= {wr_status, wr_ident, wr_start};
      end
      rd_entry_ff <= slot_mem[rd_addr];
      rd_hit_ff   <= written_ff[rd_addr];
      rd_zero_ff  <= (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      if (rd_hit_ff) begin
         rd_status = rd_entry_ff[ENTRY_W-1 -: 2];
         rd_ident  = rd_entry_ff[TIME_W +: ID_BITS];
         rd_start  = rd_entry_ff[TIME_W-1:0];
      end else begin
         rd_status = rd_zero_ff ? SLOT_RUNNING : SLOT_DEAD;
         rd_ident  = '0;
         rd_start  = '0;
      end
   end

endmodule

/* sv/rrts_ctrl.sv */
// ============================================================================
// rrts_ctrl
// Event sequencer: reads the running slot, scans the slot memory in circular
// order one slot per cycle, writes back the changed slots and forms the result.
// ============================================================================
module rrts_ctrl
   import rrts_pkg::*;
#(
   parameter int SLOT_COUNT = 32,
   parameter int ID_BITS    = 16,
   localparam int SLOT_W    = $clog2(SLOT_COUNT),
   localparam int ALIVE_W   = $clog2(SLOT_COUNT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   input  logic [QUANTUM_W-1:0] quantum,
   output logic                 res_valid,
   output rsp_payload_type      res_payload,
   input  logic                 res_take,
   output logic [SLOT_W-1:0]    mem_rd_addr,
   input  logic [1:0]           mem_rd_status,
   input  logic [ID_BITS-1:0]   mem_rd_ident,
   input  logic [TIME_W-1:0]    mem_rd_start,
   output logic                 mem_wr_en,
   output logic [SLOT_W-1:0]    mem_wr_addr,
   output logic [1:0]           mem_wr_status,
   output logic [ID_BITS-1:0]   mem_wr_ident,
   output logic [TIME_W-1:0]    mem_wr_start
);

   sched_state_type     state_ff, state_in;
   logic [SLOT_W-1:0]   running_ff, running_in;
   logic [ALIVE_W-1:0]  alive_ff, alive_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic                halted_ff, halted_in;
   logic                chk_valid_ff, chk_valid_in;

   logic [1:0]          mode_ff, mode_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [ID_BITS-1:0]  cur_ident_ff, cur_ident_in;
   logic [TIME_W-1:0]   cur_start_ff, cur_start_in;
   logic [SLOT_W-1:0]   nxt_slot_ff, nxt_slot_in;
   logic [ID_BITS-1:0]  nxt_ident_ff, nxt_ident_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   issue_ff, issue_in;
   logic [SLOT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [SLOT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]          want_ff, want_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [ID_BITS-1:0]  res_tid_ff, res_tid_in;
   logic                res_sw_ff, res_sw_in;

   logic [ID_BITS-1:0]  new_id;
   logic [TIME_W-1:0]   run_time;
   logic [31:0]         tid_wide;
   logic [31:0]         slot_wide;
   logic [31:0]         alive_wide;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W-1:0] res;
      if (idx == SLOT_W'(SLOT_COUNT - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   assign new_id   = id_ff + 1'b1;
   assign run_time = now_ff - mem_rd_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         alive_ff     <= ALIVE_W'(1);
         id_ff        <= '0;
         halted_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         alive_ff     <= alive_in;
         id_ff        <= id_in;
         halted_ff    <= halted_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      now_ff        <= now_in;
      cur_ident_ff  <= cur_ident_in;
      cur_start_ff  <= cur_start_in;
      nxt_slot_ff   <= nxt_slot_in;
      nxt_ident_ff  <= nxt_ident_in;
      found_ff      <= found_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      cnt_ff        <= cnt_in;
      want_ff       <= want_in;
      res_status_ff <= res_status_in;
      res_tid_ff    <= res_tid_in;
      res_sw_ff     <= res_sw_in;
   end

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      alive_in      = alive_ff;
      id_in         = id_ff;
      halted_in     = halted_ff;
      chk_valid_in  = chk_valid_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      cur_ident_in  = cur_ident_ff;
      cur_start_in  = cur_start_ff;
      nxt_slot_in   = nxt_slot_ff;
      nxt_ident_in  = nxt_ident_ff;
      found_in      = found_ff;
      issue_in      = issue_ff;
      chk_idx_in    = chk_idx_ff;
      cnt_in        = cnt_ff;
      want_in       = want_ff;
      res_status_in = res_status_ff;
      res_tid_in    = res_tid_ff;
      res_sw_in     = res_sw_ff;

      req_stall     = 1'b1;
      res_valid     = 1'b0;
      mem_rd_addr   = running_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = nxt_slot_ff;
      mem_wr_status = SLOT_RUNNING;
      mem_wr_ident  = nxt_ident_ff;
      mem_wr_start  = now_ff;

      unique case (state_ff)
         S_IDLE: begin
            // The running slot is read here, so its entry is ready in S_DECIDE.
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in = req_payload.mode;
               now_in  = req_payload.now_ms;
               if (halted_ff) begin
                  res_status_in = RSP_HALTED;
                  res_tid_in    = '0;
                  res_sw_in     = 1'b0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            cur_ident_in  = mem_rd_ident;
            cur_start_in  = mem_rd_start;
            res_status_in = RSP_OK;
            res_tid_in    = mem_rd_ident;
            res_sw_in     = 1'b0;
            issue_in      = slot_next(running_ff);
            chk_valid_in  = 1'b0;
            cnt_in        = '0;
            found_in      = 1'b0;
            state_in      = S_RESP;
            unique case (mode_ff)
               MODE_CREATE: begin
                  want_in  = SLOT_DEAD;
                  state_in = S_SCAN;
               end
               MODE_EXIT: begin
                  want_in   = SLOT_READY;
                  res_sw_in = 1'b1;
                  state_in  = S_SCAN;
               end
               MODE_YIELD: begin
                  if (run_time > TIME_W'(quantum)) begin
                     want_in   = SLOT_READY;
                     res_sw_in = 1'b1;
                     state_in  = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // Reads are issued one slot ahead of the compare.
            mem_rd_addr  = issue_ff;
            issue_in     = slot_next(issue_ff);
            chk_idx_in   = issue_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (mem_rd_status == want_ff) begin
                  found_in     = 1'b1;
                  nxt_slot_in  = chk_idx_ff;
                  nxt_ident_in = mem_rd_ident;
                  state_in     = (mode_ff == MODE_CREATE) ? S_WR_NEW : S_WR_OLD;
               end else if (cnt_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  unique case (mode_ff)
                     MODE_CREATE: begin
                        res_status_in = RSP_NO_SLOT;
                        state_in      = S_RESP;
                     end
                     MODE_EXIT: begin
                        halted_in     = 1'b1;
                        res_status_in = RSP_HALTED;
                        res_tid_in    = '0;
                        state_in      = S_WR_OLD;
                     end
                     default: begin
                        // A yield with no other ready slot restarts the running one.
                        nxt_slot_in  = running_ff;
                        nxt_ident_in = cur_ident_ff;
                        state_in     = S_WR_NEW;
                     end
                  endcase
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_WR_OLD: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = running_ff;
            mem_wr_start = cur_start_ff;
            if (mode_ff == MODE_EXIT) begin
               mem_wr_status = SLOT_DEAD;
               mem_wr_ident  = '0;
               if (alive_ff != '0) begin
                  alive_in = alive_ff - 1'b1;
               end
            end else begin
               mem_wr_status = SLOT_READY;
               mem_wr_ident  = cur_ident_ff;
            end
            state_in = found_ff ? S_WR_NEW : S_RESP;
         end
         S_WR_NEW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = nxt_slot_ff;
            if (mode_ff == MODE_CREATE) begin
               mem_wr_status = SLOT_READY;
               mem_wr_ident  = new_id;
               id_in         = new_id;
               alive_in      = alive_ff + 1'b1;
               res_tid_in    = new_id;
            end else begin
               running_in = nxt_slot_ff;
               res_tid_in = nxt_ident_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign tid_wide   = 32'(res_tid_ff);
   assign slot_wide  = 32'(running_ff);
   assign alive_wide = 32'(alive_ff);

   always_comb begin
      res_payload.status       = res_status_ff;
      res_payload.thread_id    = tid_wide[TID_W-1:0];
      res_payload.current_slot = slot_wide[CSLOT_W-1:0];
      res_payload.switched     = res_sw_ff;
      res_payload.live_count   = alive_wide[LIVE_W-1:0];
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start the sequencer");

   a_live_nonzero: assert property (@(posedge clock) disable iff (reset)
      !halted_ff |-> (alive_ff != '0))
      else $error("no live slot while not halted");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      alive_ff <= ALIVE_W'(SLOT_COUNT))
      else $error("live count exceeds slot count");

endmodule

/* sv/round_robin_thread_slot_scheduler.sv */
// ============================================================================
// round_robin_thread_slot_scheduler
// Round robin scheduler over a table of thread slots.
//
// Each request beat is one thread event (create, exit or yield) with the
// current time; each event yields exactly one response beat with the status,
// thread id, running slot, switch flag and live slot count. Both channels use
// valid/stall. The csr channel writes the yield quantum (ms) and is always
// ready; write it only while no event is in flight.
// Once the block has halted an event goes from idle straight to the response;
// otherwise it passes the decide state, and a search then scans the slot
// table, which is read one slot per cycle through the single read port of
// the slot memory. One event is processed at a time; the next request
// beat is taken as soon as the sequencer is back in idle, even while the last
// response beat is stalled in the output register. Reset leaves slot zero
// running, all others dead, the quantum at 200 ms; no clearing pass is needed.
// A stalled response holds its beat and the sequencer waits before
// overwriting it.
// ============================================================================
module round_robin_thread_slot_scheduler
   import rrts_pkg::*;
#(
   parameter int SLOT_COUNT = 32,
   parameter int ID_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [QUANTUM_W-1:0] csr_data
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);

   logic [QUANTUM_W-1:0] quantum_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff;

   logic                 res_valid;
   logic                 res_take;
   rsp_payload_type      res_payload;

   logic [SLOT_W-1:0]    mem_rd_addr;
   logic [1:0]           mem_rd_status;
   logic [ID_BITS-1:0]   mem_rd_ident;
   logic [TIME_W-1:0]    mem_rd_start;
   logic                 mem_wr_en;
   logic [SLOT_W-1:0]    mem_wr_addr;
   logic [1:0]           mem_wr_status;
   logic [ID_BITS-1:0]   mem_wr_ident;
   logic [TIME_W-1:0]    mem_wr_start;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_valid && csr_ready) begin
         quantum_ff <= csr_data;
      end
   end

   // The output register is free when empty or when its beat leaves now.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   rrts_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .ID_BITS    (ID_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .quantum       (quantum_ff),
      .res_valid     (res_valid),
      .res_payload   (res_payload),
      .res_take      (res_take),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_status (mem_rd_status),
      .mem_rd_ident  (mem_rd_ident),
      .mem_rd_start  (mem_rd_start),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_status (mem_wr_status),
      .mem_wr_ident  (mem_wr_ident),
      .mem_wr_start  (mem_wr_start)
   );

   rrts_slot_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .ID_BITS    (ID_BITS)
   ) u_slot_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (mem_rd_addr),
      .rd_status (mem_rd_status),
      .rd_ident  (mem_rd_ident),
      .rd_start  (mem_rd_start),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_status (mem_wr_status),
      .wr_ident  (mem_wr_ident),
      .wr_start  (mem_wr_start)
   );

endmodule
